[design/merge_sorter_macros.svh]
// Assertion macros for the merge sorter RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ms_pkg.sv]
// Package for the merge sorter: default sizes, controller state and the
// control bundle broadcast to the sorting cells. No dependencies.
`default_nettype none

package ms_pkg;

  localparam int unsigned DefaultDepth     = 64;
  localparam int unsigned DefaultDataWidth = 32;

  typedef enum logic {
    StLoad,
    StDrain
  } ms_state_e;

  typedef struct packed {
    logic insert;
    logic drain;
  } ms_ctrl_t;

endpackage

`default_nettype wire

[design/ms_cell.sv]
// One sorting cell: holds a single element and its valid bit.
// Depends on ms_pkg for the control bundle.
`default_nettype none

module ms_cell #(
  parameter int unsigned DATA_WIDTH = ms_pkg::DefaultDataWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ms_pkg::ms_ctrl_t             ctrl_i,
  input  wire logic signed [DATA_WIDTH-1:0] new_value_i,
  input  wire logic signed [DATA_WIDTH-1:0] left_value_i,
  input  wire logic                         left_valid_i,
  input  wire logic                         left_moves_i,
  input  wire logic signed [DATA_WIDTH-1:0] right_value_i,
  input  wire logic                         right_valid_i,
  output logic signed [DATA_WIDTH-1:0]      value_o,
  output logic                              valid_o,
  output logic                              moves_o
);

  logic signed [DATA_WIDTH-1:0] value_q, value_d;
  logic                         valid_q, valid_d;

  // A held element steps right when the new element sorts strictly before it,
  // so equal elements keep their arrival order.
  assign moves_o = valid_q && (value_q > new_value_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (left_moves_i) begin
        value_d = left_value_i;
        valid_d = 1'b1;
      end else if (left_valid_i && (moves_o || !valid_q)) begin
        value_d = new_value_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.drain) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[design/ms_ctrl.sv]
// Controller for the merge sorter: counts the batch, ends it on last or
// when the cells are full, then paces the drain. Depends on ms_pkg.
`default_nettype none

module ms_ctrl #(
  parameter int unsigned DEPTH = ms_pkg::DefaultDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        last_i,
  output ms_pkg::ms_ctrl_t ctrl_o,
  output logic             busy_o,
  output logic             result_valid_o,
  output logic             final_res_o
);

  localparam int unsigned CountWidth = $clog2(DEPTH + 1);

  ms_pkg::ms_state_e     state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  accept;
  logic                  batch_end;
  logic                  drain_end;

  assign accept    = start_i && (state_q == ms_pkg::StLoad);
  assign batch_end = last_i || (count_q + CountWidth'(1) == CountWidth'(DEPTH));
  assign drain_end = (count_q == CountWidth'(1));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ms_pkg::StLoad: begin
        if (accept) begin
          count_d = count_q + CountWidth'(1);
          if (batch_end) begin
            state_d = ms_pkg::StDrain;
          end
        end
      end
      ms_pkg::StDrain: begin
        count_d = count_q - CountWidth'(1);
        if (drain_end) begin
          state_d = ms_pkg::StLoad;
        end
      end
      default: begin
        state_d = ms_pkg::StLoad;
        count_d = '0;
      end
    endcase
  end

  always_comb begin
    ctrl_o.insert  = 1'b0;
    ctrl_o.drain   = 1'b0;
    busy_o         = 1'b0;
    result_valid_o = 1'b0;
    final_res_o    = 1'b0;
    unique case (state_q)
      ms_pkg::StLoad: begin
        ctrl_o.insert = accept;
      end
      ms_pkg::StDrain: begin
        ctrl_o.drain   = 1'b1;
        busy_o         = 1'b1;
        result_valid_o = 1'b1;
        final_res_o    = drain_end;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ms_pkg::StLoad;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[design/merge_sorter.sv]
// Top level of the merge sorter: a row of sorting cells and its controller.
// Depends on ms_pkg, ms_cell, ms_ctrl and merge_sorter_macros.svh.
`default_nettype none

`include "merge_sorter_macros.svh"

// Each request (start_i high while busy_o is low) takes one element; the
// row of DEPTH cells inserts it into sorted position at once, so elements
// can be taken back to back while loading. After the element flagged last, or the
// one that fills all DEPTH cells, busy_o rises and the batch drains from the
// head of the row, one element per cycle with result_valid_o high, ascending
// and stable for equal values; final_res_o marks the last one. Results are
// shown for a single cycle each and must be taken then, as the receiver
// cannot stall.
module merge_sorter #(
  parameter int unsigned DEPTH      = ms_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = ms_pkg::DefaultDataWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [DATA_WIDTH-1:0] value_i,
  input  wire logic                         last_i,
  output logic                              result_valid_o,
  output logic signed [DATA_WIDTH-1:0]      sorted_value_o,
  output logic                              final_res_o
);

  ms_pkg::ms_ctrl_t             ctrl;
  logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];
  logic                         cell_valid [DEPTH];
  logic                         cell_moves [DEPTH];

  ms_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .last_i         (last_i),
    .ctrl_o         (ctrl),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .final_res_o    (final_res_o)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_value;
    logic                         left_valid;
    logic                         left_moves;
    logic signed [DATA_WIDTH-1:0] right_value;
    logic                         right_valid;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b1;
      assign left_moves = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_moves = cell_moves[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ms_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_value_i   (value_i),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .left_moves_i  (left_moves),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .moves_o       (cell_moves[i])
    );
  end

  assign sorted_value_o = cell_value[0];

  // Every result strobe must come from an occupied head cell.
  `MS_ASSERT_NOW(a_result_from_valid_head, result_valid_o, cell_valid[0], "result from empty cell")
  // After the final result all cells are empty and requests are taken again.
  `MS_ASSERT_NEXT(a_final_frees_block, result_valid_o && final_res_o, !busy_o && !cell_valid[0], "block not free after final result")
  // A request flagged last starts the drain in the next cycle.
  `MS_ASSERT_NEXT(a_last_starts_drain, start_i && !busy_o && last_i, busy_o && result_valid_o, "drain did not start after last")

endmodule

`default_nettype wire
